FILE: design/mfd_pkg.sv
package mfd_pkg;

   localparam int DEFAULT_DISPLAY_WIDTH  = 128;
   localparam int DEFAULT_DISPLAY_HEIGHT = 64;

   localparam logic [7:0] FILL_ONES  = 8'hFF;
   localparam logic [7:0] FILL_ZEROS = 8'h00;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [2:0] {
      CMD_FILL  = 3'd0,
      CMD_PIXEL = 3'd1,
      CMD_HLINE = 3'd2,
      CMD_VLINE = 3'd3,
      CMD_RECT  = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NARROW_MODE   = 2'd0,
      CSR_INVERT_COLORS = 2'd1,
      CSR_DRAW_COLOR    = 2'd2
   } csr_index_type;

   // rectangle edges, also used for single lines and pixels
   typedef enum logic [1:0] {
      SEG_TOP    = 2'd0,
      SEG_BOTTOM = 2'd1,
      SEG_LEFT   = 2'd2,
      SEG_RIGHT  = 2'd3
   } seg_type;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'd0,
      ST_IDLE   = 4'd1,
      ST_SEG    = 4'd2,
      ST_READ   = 4'd3,
      ST_WRITE  = 4'd4,
      ST_FILL   = 4'd5,
      ST_RDREQ  = 4'd6,
      ST_RDDATA = 4'd7,
      ST_DONE   = 4'd8
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic       pixel_color;
      logic [9:0] read_address;
   } item_type;

   typedef struct packed {
      logic narrow_mode;
      logic invert_colors;
      logic draw_color;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

endpackage

FILE: design/mfd_store.sv
module mfd_store #(
   parameter int STORE_DEPTH = 1024,
   parameter int ADDR_W      = 10
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mfd_seq.sv
module mfd_seq #(
   parameter int DISPLAY_WIDTH  = mfd_pkg::DEFAULT_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = mfd_pkg::DEFAULT_DISPLAY_HEIGHT,
   parameter int STORE_DEPTH    = 1024,
   parameter int ADDR_W         = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mfd_pkg::item_type    item,
   input  mfd_pkg::cfg_type     cfg,
   input  logic                 out_free,
   output mfd_pkg::seq_stat_type stat,
   output logic [7:0]           result,
   output logic                 mem_rd_en,
   output logic                 mem_wr_en,
   output logic [ADDR_W-1:0]    mem_addr,
   output logic [7:0]           mem_wr_data,
   input  logic [7:0]           mem_rd_data
);

   mfd_pkg::state_type state_ff, state_in;
   mfd_pkg::item_type  item_ff, item_in;
   mfd_pkg::seg_type   seg_ff, seg_in, last_seg_ff, last_seg_in;
   mfd_pkg::cmd_type   start_cmd;
   logic               color_ff, color_in;
   logic [7:0]         pos_ff, pos_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [7:0]         fill_byte_ff, fill_byte_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [7:0]         mask_ff, mask_in;
   logic               hit_ff, hit_in;
   logic [7:0]         result_ff, result_in;

   logic               horiz;
   logic [7:0]         seg_fixed, seg_start, seg_end;
   logic               seg_empty, seg_last, pos_last, sweep_last;
   logic [7:0]         px, py, py_n;
   logic               in_area;
   logic [ADDR_W-1:0]  pix_addr;
   logic [7:0]         pix_mask;
   logic [31:0]        rd_wide;
   logic               rd_in_range;
   logic [7:0]         modified;

   assign start_cmd = mfd_pkg::cmd_type'(item.command);

   // current edge of the shape
   always_comb begin
      unique case (seg_ff)
         mfd_pkg::SEG_TOP:    seg_fixed = item_ff.y_start;
         mfd_pkg::SEG_BOTTOM: seg_fixed = item_ff.y_end;
         mfd_pkg::SEG_LEFT:   seg_fixed = item_ff.x_start;
         mfd_pkg::SEG_RIGHT:  seg_fixed = item_ff.x_end;
         default:             seg_fixed = item_ff.y_start;
      endcase
   end

   assign horiz      = (seg_ff == mfd_pkg::SEG_TOP) || (seg_ff == mfd_pkg::SEG_BOTTOM);
   assign seg_start  = horiz ? item_ff.x_start : item_ff.y_start;
   assign seg_end    = horiz ? item_ff.x_end : item_ff.y_end;
   assign seg_empty  = seg_end < seg_start;
   assign seg_last   = seg_ff == last_seg_ff;
   assign pos_last   = pos_ff == seg_end;
   assign sweep_last = sweep_ff == ADDR_W'(STORE_DEPTH - 1);

   // pixel address and bit
   assign px       = horiz ? pos_ff : seg_fixed;
   assign py       = horiz ? seg_fixed : pos_ff;
   assign py_n     = cfg.narrow_mode ? {py[6:0], 1'b1} : py;
   assign in_area  = ({1'b0, px} < 9'(DISPLAY_WIDTH)) && ({1'b0, py_n} < 9'(DISPLAY_HEIGHT));
   assign pix_addr = ADDR_W'(int'(px) + int'(py_n[7:3]) * DISPLAY_WIDTH);
   assign pix_mask = 8'd1 << py_n[2:0];

   assign rd_wide     = 32'(item_ff.read_address);
   assign rd_in_range = rd_wide < 32'(STORE_DEPTH);

   assign modified = color_ff ? (mem_rd_data | mask_ff) : (mem_rd_data & ~mask_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfd_pkg::ST_CLEAR: begin
            if (sweep_last) state_in = mfd_pkg::ST_IDLE;
         end
         mfd_pkg::ST_IDLE: begin
            if (start) begin
               unique case (start_cmd)
                  mfd_pkg::CMD_FILL:  state_in = mfd_pkg::ST_FILL;
                  mfd_pkg::CMD_PIXEL: state_in = mfd_pkg::ST_SEG;
                  mfd_pkg::CMD_HLINE: state_in = mfd_pkg::ST_SEG;
                  mfd_pkg::CMD_VLINE: state_in = mfd_pkg::ST_SEG;
                  mfd_pkg::CMD_RECT:  state_in = mfd_pkg::ST_SEG;
                  mfd_pkg::CMD_READ:  state_in = mfd_pkg::ST_RDREQ;
                  default:            state_in = mfd_pkg::ST_DONE;
               endcase
            end
         end
         mfd_pkg::ST_SEG: begin
            if (!seg_empty) state_in = mfd_pkg::ST_READ;
            else if (seg_last) state_in = mfd_pkg::ST_DONE;
         end
         mfd_pkg::ST_READ: state_in = mfd_pkg::ST_WRITE;
         mfd_pkg::ST_WRITE: begin
            if (!pos_last) state_in = mfd_pkg::ST_READ;
            else if (seg_last) state_in = mfd_pkg::ST_DONE;
            else state_in = mfd_pkg::ST_SEG;
         end
         mfd_pkg::ST_FILL: begin
            if (sweep_last) state_in = mfd_pkg::ST_DONE;
         end
         mfd_pkg::ST_RDREQ:  state_in = mfd_pkg::ST_RDDATA;
         mfd_pkg::ST_RDDATA: state_in = mfd_pkg::ST_DONE;
         mfd_pkg::ST_DONE: begin
            if (out_free) state_in = mfd_pkg::ST_IDLE;
         end
         default: state_in = mfd_pkg::ST_IDLE;
      endcase
   end

   // memory control and datapath
   always_comb begin
      item_in      = item_ff;
      color_in     = color_ff;
      seg_in       = seg_ff;
      last_seg_in  = last_seg_ff;
      pos_in       = pos_ff;
      sweep_in     = sweep_ff;
      fill_byte_in = fill_byte_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      hit_in       = hit_ff;
      result_in    = result_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_addr     = sweep_ff;
      mem_wr_data  = fill_byte_ff;
      unique case (state_ff)
         mfd_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mfd_pkg::FILL_ZEROS;
            sweep_in    = sweep_ff + 1'b1;
         end
         mfd_pkg::ST_IDLE: begin
            if (start) begin
               item_in      = item;
               result_in    = 8'd0;
               sweep_in     = '0;
               fill_byte_in = item.pixel_color ? mfd_pkg::FILL_ONES : mfd_pkg::FILL_ZEROS;
               color_in     = cfg.draw_color ^ cfg.invert_colors;
               seg_in       = mfd_pkg::SEG_TOP;
               last_seg_in  = mfd_pkg::SEG_TOP;
               if (start_cmd == mfd_pkg::CMD_PIXEL) begin
                  item_in.x_end = item.x_start;
                  color_in      = item.pixel_color ^ cfg.invert_colors;
               end
               if (start_cmd == mfd_pkg::CMD_VLINE) begin
                  seg_in      = mfd_pkg::SEG_LEFT;
                  last_seg_in = mfd_pkg::SEG_LEFT;
               end
               if (start_cmd == mfd_pkg::CMD_RECT) begin
                  last_seg_in = mfd_pkg::SEG_RIGHT;
               end
            end
         end
         mfd_pkg::ST_SEG: begin
            if (seg_empty) begin
               if (!seg_last) seg_in = mfd_pkg::seg_type'(seg_ff + 2'd1);
            end else begin
               pos_in = seg_start;
            end
         end
         mfd_pkg::ST_READ: begin
            mem_rd_en = 1'b1;
            mem_addr  = pix_addr;
            addr_in   = pix_addr;
            mask_in   = pix_mask;
            hit_in    = in_area;
         end
         mfd_pkg::ST_WRITE: begin
            mem_wr_en   = hit_ff;
            mem_addr    = addr_ff;
            mem_wr_data = modified;
            if (pos_last) begin
               if (!seg_last) seg_in = mfd_pkg::seg_type'(seg_ff + 2'd1);
            end else begin
               pos_in = pos_ff + 8'd1;
            end
         end
         mfd_pkg::ST_FILL: begin
            mem_wr_en = 1'b1;
            sweep_in  = sweep_ff + 1'b1;
         end
         mfd_pkg::ST_RDREQ: begin
            mem_rd_en = 1'b1;
            mem_addr  = rd_wide[ADDR_W-1:0];
         end
         mfd_pkg::ST_RDDATA: begin
            result_in = rd_in_range ? mem_rd_data : 8'd0;
         end
         mfd_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfd_pkg::ST_CLEAR;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      color_ff     <= color_in;
      seg_ff       <= seg_in;
      last_seg_ff  <= last_seg_in;
      pos_ff       <= pos_in;
      fill_byte_ff <= fill_byte_in;
      addr_ff      <= addr_in;
      mask_ff      <= mask_in;
      hit_ff       <= hit_in;
      result_ff    <= result_in;
   end

   assign stat.idle = state_ff == mfd_pkg::ST_IDLE;
   assign stat.done = state_ff == mfd_pkg::ST_DONE;
   assign result    = result_ff;

endmodule

FILE: design/mono_framebuffer_draw.sv
// Page-organized monochrome framebuffer with drawing commands. Each byte of the frame memory
// holds eight stacked pixels of one column. After reset the block clears the memory one byte
// per cycle and holds req_stall high until all DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes
// (1024 at the default size) are cleared. One transaction is worked at a time; every pixel is
// a read-modify-write through the single frame memory port, a read state and then a write
// state. A line works its pixels in turn and a rectangle its edges, each edge set up in its own
// state; fill writes the whole memory and a read byte passes a request and a data state. Every
// transaction gives one result; read_byte is zero except for the read command.
module mono_framebuffer_draw #(
   parameter int DISPLAY_WIDTH  = mfd_pkg::DEFAULT_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = mfd_pkg::DEFAULT_DISPLAY_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_command,
   input  logic [7:0]                      req_x_start,
   input  logic [7:0]                      req_y_start,
   input  logic [7:0]                      req_x_end,
   input  logic [7:0]                      req_y_end,
   input  logic                            req_pixel_color,
   input  logic [9:0]                      req_read_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_read_byte,
   input  logic                            csr_write_enable,
   input  logic [mfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                            csr_write_data
);

   localparam int STORE_PAGES = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH = DISPLAY_WIDTH * STORE_PAGES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   mfd_pkg::cfg_type      cfg;
   mfd_pkg::item_type     item;
   mfd_pkg::seq_stat_type stat;
   logic                  narrow_mode_ff, invert_colors_ff, draw_color_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_read_byte_ff;
   logic                  start, out_free, load;
   logic [7:0]            result;
   logic                  mem_rd_en, mem_wr_en;
   logic [ADDR_W-1:0]     mem_addr;
   logic [7:0]            mem_wr_data, mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_mode_ff   <= 1'b1;
         invert_colors_ff <= 1'b0;
         draw_color_ff    <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (mfd_pkg::csr_index_type'(csr_index))
            mfd_pkg::CSR_NARROW_MODE:   narrow_mode_ff   <= csr_write_data;
            mfd_pkg::CSR_INVERT_COLORS: invert_colors_ff <= csr_write_data;
            mfd_pkg::CSR_DRAW_COLOR:    draw_color_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.narrow_mode   = narrow_mode_ff;
   assign cfg.invert_colors = invert_colors_ff;
   assign cfg.draw_color    = draw_color_ff;

   assign item.command      = req_command;
   assign item.x_start      = req_x_start;
   assign item.y_start      = req_y_start;
   assign item.x_end        = req_x_end;
   assign item.y_end        = req_y_end;
   assign item.pixel_color  = req_pixel_color;
   assign item.read_address = req_read_address;

   assign req_stall = !stat.idle;
   assign start     = req_valid && stat.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = stat.done && out_free;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_read_byte_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

   mfd_seq #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
      .STORE_DEPTH    (STORE_DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .item        (item),
      .cfg         (cfg),
      .out_free    (out_free),
      .stat        (stat),
      .result      (result),
      .mem_rd_en   (mem_rd_en),
      .mem_wr_en   (mem_wr_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   mfd_store #(
      .STORE_DEPTH (STORE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: design/mfd_checker.sv
module mfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_byte
);

   // clearing pass follows reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("no clearing pass after reset");

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new transaction taken while busy");

   // a result only comes out of work in progress
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_byte)))
      else $error("stalled result changed");

endmodule

bind mono_framebuffer_draw mfd_checker u_mfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_byte (rsp_read_byte)
);
